### rtl/swb_pkg.sv
package swb_pkg;

  localparam int NUM_WORDS_DEF = 128;

  localparam int KIND_W = 3;
  localparam int LBA_W  = 7;
  localparam int DATA_W = 32;
  localparam int LEN_W  = 8;
  localparam int THR_W  = 4;

  localparam logic [THR_W-1:0] THRESH_RST = 4'd10;

  typedef enum logic [KIND_W-1:0] {
    K_WRITE   = 3'd0,
    K_READ    = 3'd1,
    K_ERASE   = 3'd2,
    K_FLUSH   = 3'd3,
    K_FULL    = 3'd4,
    K_DISCARD = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    SW_NONE,
    SW_CLEAR,
    SW_COMMIT,
    SW_FILL,
    SW_DROP
  } sweep_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_ERASE,
    ST_COMMIT,
    ST_FILL,
    ST_DROP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic   accept;
    logic   pend_wr;
    logic   rd_en;
    logic   res_read;
    logic   bump;
    logic   cnt_zero;
    logic   set_flushed;
    logic   erase_wr;
    logic   ptr_clr;
    logic   out_load;
    sweep_t sweep;
  } ctl_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              err;
    logic              hit;
    logic              erase_more;
    logic              ptr_last;
    logic              ptr_end;
    logic              out_free;
    logic              in_fire;
  } sts_t;

endpackage

### rtl/swb_cmd_if.sv
interface swb_cmd_if;
  import swb_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [LBA_W-1:0]  lba;
  logic [DATA_W-1:0] data;
  logic [LEN_W-1:0]  length;

  modport source (output valid, output kind, output lba, output data, output length,
                  input ready);
  modport sink   (input valid, input kind, input lba, input data, input length,
                  output ready);
endinterface

### rtl/swb_rsp_if.sv
interface swb_rsp_if;
  import swb_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              flushed;
  logic              error;

  modport source (output valid, output read_data, output flushed, output error,
                  input ready);
  modport sink   (input valid, input read_data, input flushed, input error,
                  output ready);
endinterface

### rtl/swb_ctrl.sv
module swb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  swb_pkg::sts_t sts,
  output swb_pkg::ctl_t ctl
);
  import swb_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        ctl.sweep = SW_CLEAR;
        if (sts.ptr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ctl.accept = 1'b1;
        if (sts.in_fire) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.err) begin
          state_next = ST_DONE;
        end else begin
          unique case (kind_t'(sts.kind))
            K_WRITE: begin
              ctl.pend_wr = 1'b1;
              ctl.bump    = 1'b1;
              if (sts.hit) begin
                ctl.ptr_clr = 1'b1;
                state_next  = ST_COMMIT;
              end else begin
                state_next = ST_DONE;
              end
            end
            K_READ: begin
              ctl.rd_en  = 1'b1;
              state_next = ST_READ;
            end
            K_ERASE: begin
              state_next = ST_ERASE;
            end
            K_FLUSH: begin
              ctl.set_flushed = 1'b1;
              ctl.cnt_zero    = 1'b1;
              state_next      = ST_COMMIT;
            end
            K_FULL: begin
              ctl.cnt_zero = 1'b1;
              state_next   = ST_FILL;
            end
            K_DISCARD: begin
              ctl.cnt_zero = 1'b1;
              state_next   = ST_DROP;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_READ: begin
        ctl.res_read = 1'b1;
        state_next   = ST_DONE;
      end
      ST_ERASE: begin
        if (sts.erase_more) begin
          ctl.erase_wr = 1'b1;
        end else begin
          ctl.bump = 1'b1;
          if (sts.hit) begin
            ctl.ptr_clr = 1'b1;
            state_next  = ST_COMMIT;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_COMMIT: begin
        ctl.sweep = SW_COMMIT;
        if (sts.ptr_end) begin
          state_next = ST_DONE;
        end
      end
      ST_FILL: begin
        ctl.sweep = SW_FILL;
        if (sts.ptr_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DROP: begin
        ctl.sweep = SW_DROP;
        if (sts.ptr_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_erase_end_bumps: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ERASE && !sts.erase_more) |-> ctl.bump)
    else $error("erase finished without bumping count");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> sts.out_free)
    else $error("result loaded over an untaken word");

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && sts.in_fire) |=> state == ST_DECODE)
    else $error("accepted word not decoded");

endmodule

### rtl/swb_dp.sv
module swb_dp #(
  parameter int NUM_WORDS = swb_pkg::NUM_WORDS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  swb_cmd_if.sink                   cmd,
  swb_rsp_if.source                 rsp,
  input  logic                      cfg_we,
  input  logic [swb_pkg::THR_W-1:0] cfg_data,
  input  swb_pkg::ctl_t             ctl,
  output swb_pkg::sts_t             sts
);
  import swb_pkg::*;

  localparam int AW = $clog2(NUM_WORDS);
  localparam int PW = AW + 1;
  localparam int SW = (PW > LEN_W + 1) ? PW : LEN_W + 1;
  localparam int LW = (AW > LBA_W) ? AW : LBA_W;
  localparam logic [PW-1:0] PTR_END  = PW'(NUM_WORDS);
  localparam logic [PW-1:0] PTR_LAST = PW'(NUM_WORDS - 1);
  localparam logic [SW-1:0] N_S      = SW'(NUM_WORDS);

  logic [DATA_W-1:0] store_mem [NUM_WORDS];
  logic [DATA_W:0]   pend_mem  [NUM_WORDS];

  logic [KIND_W-1:0] k_kind;
  logic [DATA_W-1:0] k_data;
  logic [AW-1:0]     k_addr;
  logic              k_err;
  logic [PW-1:0]     erase_end;
  logic [PW-1:0]     ptr;
  logic [AW-1:0]     ptr_d;
  logic              cm_v;
  logic [THR_W-1:0]  count;
  logic [THR_W-1:0]  thresh;
  logic [DATA_W-1:0] res_rd;
  logic              res_fl;
  logic [DATA_W-1:0] store_q;
  logic [DATA_W:0]   pend_q;
  logic              rsp_v;
  logic [DATA_W-1:0] rsp_rd;
  logic              rsp_fl;
  logic              rsp_err;

  logic              in_fire;
  logic [LW-1:0]     lba_l;
  logic [AW-1:0]     lba_a;
  logic [SW-1:0]     lba_s;
  logic [SW-1:0]     sum_s;
  logic              in_err;
  logic [THR_W-1:0]  cnt1;
  logic              hit;
  logic              ptr_end;
  logic              commit_rd;
  logic              rd_en;
  logic [AW-1:0]     raddr;
  logic              ptr_inc;
  logic              pend_we;
  logic [AW-1:0]     pend_wa;
  logic [DATA_W:0]   pend_wd;
  logic              store_we;
  logic [AW-1:0]     store_wa;
  logic [DATA_W-1:0] store_wd;

  assign cmd.ready = ctl.accept;
  assign in_fire   = cmd.valid && ctl.accept;

  assign lba_l  = LW'(cmd.lba);
  assign lba_a  = lba_l[AW-1:0];
  assign lba_s  = SW'(cmd.lba);
  assign sum_s  = lba_s + SW'(cmd.length);
  assign in_err = (cmd.kind == K_WRITE || cmd.kind == K_READ || cmd.kind == K_ERASE)
                  && (lba_s >= N_S);

  assign cnt1    = count + THR_W'(1);
  assign hit     = cnt1 >= thresh;
  assign ptr_end = (ptr == PTR_END);

  assign commit_rd = (ctl.sweep == SW_COMMIT) && !ptr_end;
  assign rd_en     = ctl.rd_en || commit_rd;
  assign raddr     = ctl.rd_en ? k_addr : ptr[AW-1:0];
  assign ptr_inc   = ctl.erase_wr || commit_rd || ctl.sweep == SW_CLEAR
                     || ctl.sweep == SW_FILL || ctl.sweep == SW_DROP;

  // command capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      k_kind    <= cmd.kind;
      k_data    <= cmd.data;
      k_addr    <= lba_a;
      k_err     <= in_err;
      erase_end <= (sum_s > N_S) ? PTR_END : sum_s[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (in_fire) begin
      ptr <= (cmd.kind == K_ERASE) ? {1'b0, lba_a} : '0;
    end else if (ctl.ptr_clr) begin
      ptr <= '0;
    end else if (ptr_inc) begin
      ptr <= ptr + PW'(1);
    end
  end

  // commit write-back lands in the cycle after the pending read
  always_ff @(posedge clk) begin
    if (rst) begin
      cm_v <= 1'b0;
    end else begin
      cm_v <= commit_rd;
    end
  end

  always_ff @(posedge clk) begin
    ptr_d <= ptr[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.cnt_zero) begin
      count <= '0;
    end else if (ctl.bump) begin
      count <= hit ? '0 : cnt1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THRESH_RST;
    end else if (cfg_we) begin
      thresh <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_rd <= '0;
      res_fl <= 1'b0;
    end else begin
      if (ctl.res_read) begin
        res_rd <= pend_q[DATA_W] ? pend_q[DATA_W-1:0] : store_q;
      end
      if (ctl.set_flushed) begin
        res_fl <= 1'b1;
      end else if (ctl.bump) begin
        res_fl <= hit;
      end
    end
  end

  // memory write selection
  always_comb begin
    pend_we = 1'b0;
    pend_wa = ptr[AW-1:0];
    pend_wd = '0;
    priority if (ctl.pend_wr) begin
      pend_we = 1'b1;
      pend_wa = k_addr;
      pend_wd = {1'b1, k_data};
    end else if (ctl.erase_wr) begin
      pend_we = 1'b1;
      pend_wd = {1'b1, {DATA_W{1'b0}}};
    end else if (cm_v) begin
      pend_we = 1'b1;
      pend_wa = ptr_d;
    end else if (ctl.sweep == SW_CLEAR || ctl.sweep == SW_FILL || ctl.sweep == SW_DROP) begin
      pend_we = 1'b1;
    end else begin
      pend_we = 1'b0;
    end
  end

  always_comb begin
    store_we = 1'b0;
    store_wa = ptr[AW-1:0];
    store_wd = '0;
    priority if (cm_v) begin
      store_we = pend_q[DATA_W];
      store_wa = ptr_d;
      store_wd = pend_q[DATA_W-1:0];
    end else if (ctl.sweep == SW_CLEAR) begin
      store_we = 1'b1;
    end else if (ctl.sweep == SW_FILL) begin
      store_we = 1'b1;
      store_wd = k_data;
    end else begin
      store_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_mem[pend_wa] <= pend_wd;
    end
    if (rd_en) begin
      pend_q <= pend_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_wa] <= store_wd;
    end
    if (rd_en) begin
      store_q <= store_mem[raddr];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_v <= 1'b0;
    end else if (ctl.out_load) begin
      rsp_v <= 1'b1;
    end else if (rsp.ready) begin
      rsp_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      rsp_rd  <= res_rd;
      rsp_fl  <= res_fl;
      rsp_err <= k_err;
    end
  end

  assign rsp.valid     = rsp_v;
  assign rsp.read_data = rsp_rd;
  assign rsp.flushed   = rsp_fl;
  assign rsp.error     = rsp_err;

  assign sts.kind       = k_kind;
  assign sts.err        = k_err;
  assign sts.hit        = hit;
  assign sts.erase_more = ptr < erase_end;
  assign sts.ptr_last   = (ptr == PTR_LAST);
  assign sts.ptr_end    = ptr_end;
  assign sts.out_free   = !rsp_v || rsp.ready;
  assign sts.in_fire    = in_fire;

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr <= PTR_END)
    else $error("sweep pointer past end of store");

  a_commit_stage: assert property (@(posedge clk) disable iff (rst)
    cm_v |-> $past(ctl.sweep == SW_COMMIT))
    else $error("commit write-back outside commit sweep");

  a_hit_clears_count: assert property (@(posedge clk) disable iff (rst)
    (ctl.bump && hit && !ctl.cnt_zero) |=> count == '0)
    else $error("count not cleared on flush");

endmodule

### rtl/ssd_write_buffer_unit.sv
// One command in flight at a time; cmd.ready stays low from accept until the result
//   is loaded into the output register.
// Reset: synchronous; a clearing pass zeroes the store and pending flags with
//   cmd.ready low. Threshold resets to 10, count to zero.
module ssd_write_buffer_unit #(
  parameter int NUM_WORDS = swb_pkg::NUM_WORDS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  swb_cmd_if.sink                   cmd,
  swb_rsp_if.source                 rsp,
  input  logic                      cfg_we,
  input  logic [swb_pkg::THR_W-1:0] cfg_data
);
  import swb_pkg::*;

  ctl_t ctl;
  sts_t sts;

  swb_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .ctl (ctl)
  );

  swb_dp #(
    .NUM_WORDS (NUM_WORDS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .ctl      (ctl),
    .sts      (sts)
  );

endmodule

### verif/ssd_write_buffer_unit_test.sv
`timescale 1ns / 1ps

module ssd_write_buffer_unit_test;
  import swb_pkg::*;

  localparam int NUM_WORDS = NUM_WORDS_DEF;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE_CYCLES = NUM_WORDS + 8;
  localparam int LONG_HOLD = 400;
  localparam logic [KIND_W-1:0] KIND_UNUSED_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LBA_W-1:0]  lba;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  length;
  } buffer_cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              flushed;
    logic              error;
  } buffer_rsp_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [THR_W-1:0] cfg_data;

  swb_cmd_if cmd();
  swb_rsp_if rsp();

  ssd_write_buffer_unit #(.NUM_WORDS(NUM_WORDS)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // buffer model
  logic [DATA_W-1:0] store_word [NUM_WORDS];
  logic [DATA_W-1:0] pend_word  [NUM_WORDS];
  logic              pend_vld   [NUM_WORDS];
  logic [THR_W-1:0]  cmd_count;
  logic [THR_W-1:0]  flush_thresh;

  buffer_rsp_t expected_rsp [$];
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned hold_request;
  int unsigned hold_left;
  logic [LBA_W-1:0] hot_base;

  function automatic void drop_pending();
    for (int a = 0; a < NUM_WORDS; a++) pend_vld[a] = 1'b0;
    cmd_count = '0;
  endfunction

  function automatic void commit_pending();
    for (int a = 0; a < NUM_WORDS; a++)
      if (pend_vld[a]) store_word[a] = pend_word[a];
    drop_pending();
  endfunction

  function automatic logic count_bump();
    cmd_count = cmd_count + THR_W'(1);
    if (cmd_count >= flush_thresh) begin
      commit_pending();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic buffer_rsp_t buffer_apply(buffer_cmd_t c);
    buffer_rsp_t r;
    int n;
    r = '0;
    case (c.kind)
      K_WRITE: begin
        if (int'(c.lba) >= NUM_WORDS) begin
          r.error = 1'b1;
        end else begin
          pend_word[c.lba] = c.data;
          pend_vld[c.lba] = 1'b1;
          r.flushed = count_bump();
        end
      end
      K_READ: begin
        if (int'(c.lba) >= NUM_WORDS) r.error = 1'b1;
        else r.read_data = pend_vld[c.lba] ? pend_word[c.lba] : store_word[c.lba];
      end
      K_ERASE: begin
        if (int'(c.lba) >= NUM_WORDS) begin
          r.error = 1'b1;
        end else begin
          n = int'(c.length);
          if (n > NUM_WORDS - int'(c.lba)) n = NUM_WORDS - int'(c.lba);
          for (int a = 0; a < n; a++) begin
            pend_word[int'(c.lba) + a] = '0;
            pend_vld[int'(c.lba) + a] = 1'b1;
          end
          r.flushed = count_bump();
        end
      end
      K_FLUSH: begin
        commit_pending();
        r.flushed = 1'b1;
      end
      K_FULL: begin
        for (int a = 0; a < NUM_WORDS; a++) store_word[a] = c.data;
        drop_pending();
      end
      K_DISCARD: drop_pending();
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result checker; commands are predicted at their accept edge
  always @(posedge clk) begin : check_rsp
    buffer_rsp_t want;
    buffer_cmd_t seen;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.read_data !== want.read_data) begin
            $error("read_data mismatch: expected %08h, actual %08h",
                   want.read_data, rsp.read_data);
            fail_count++;
          end
          if (rsp.flushed !== want.flushed) begin
            $error("flushed mismatch: expected %0b, actual %0b", want.flushed, rsp.flushed);
            fail_count++;
          end
          if (rsp.error !== want.error) begin
            $error("error mismatch: expected %0b, actual %0b", want.error, rsp.error);
            fail_count++;
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        seen = '{kind: cmd.kind, lba: cmd.lba, data: cmd.data, length: cmd.length};
        expected_rsp.push_back(buffer_apply(seen));
      end
    end
  end

  // receiver; a requested hold-off is counted down here
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function automatic buffer_cmd_t cmd_of(logic [KIND_W-1:0] kind, int lba,
                                         logic [DATA_W-1:0] data, int length);
    buffer_cmd_t c;
    c.kind = kind;
    c.lba = lba[LBA_W-1:0];
    c.data = data;
    c.length = length[LEN_W-1:0];
    return c;
  endfunction

  task automatic send_word(buffer_cmd_t c);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      cmd.valid <= 1'b0;
    end
    @(negedge clk);
    cmd.valid <= 1'b1;
    cmd.kind <= c.kind;
    cmd.lba <= c.lba;
    cmd.data <= c.data;
    cmd.length <= c.length;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
  endtask

  task automatic wait_for_results(bit settle);
    @(negedge clk);
    cmd.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_flush_threshold(logic [THR_W-1:0] value);
    wait_for_results(1'b1);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    flush_thresh = value;
  endtask

  function automatic buffer_cmd_t random_cmd();
    buffer_cmd_t c;
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) c.kind = K_WRITE;
    else if (pick < 70) c.kind = K_READ;
    else if (pick < 81) c.kind = K_ERASE;
    else if (pick < 86) c.kind = K_FLUSH;
    else if (pick < 89) c.kind = K_FULL;
    else if (pick < 93) c.kind = K_DISCARD;
    else if (pick < 96) c.kind = ($urandom_range(1) != 0) ? KIND_UNUSED_6 : KIND_UNUSED_7;
    else c.kind = K_READ;
    if ($urandom_range(99) < 3) hot_base = LBA_W'($urandom_range(NUM_WORDS - 1));
    if ($urandom_range(99) < 70) c.lba = hot_base + LBA_W'($urandom_range(7));
    else c.lba = LBA_W'($urandom_range(NUM_WORDS - 1));
    pick = $urandom_range(99);
    if (pick < 10) c.data = '0;
    else if (pick < 20) c.data = '1;
    else c.data = $urandom;
    pick = $urandom_range(99);
    if (pick < 70) c.length = LEN_W'($urandom_range(8));
    else if (pick < 90) c.length = LEN_W'($urandom_range(255));
    else c.length = LEN_W'(NUM_WORDS - int'(c.lba));
    return c;
  endfunction

  task automatic run_random_traffic(int unsigned count);
    buffer_cmd_t c;
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      c = random_cmd();
      send_word(c);
      if (c.kind != KIND_UNUSED_6 && c.kind != KIND_UNUSED_7) sent++;
      if ($urandom_range(99) == 0) wait_for_results(1'b0);
    end
  endtask

  task automatic test_directed_commands();
    send_word(cmd_of(K_READ, 0, '0, 0));
    send_word(cmd_of(K_WRITE, 0, 32'hFFFF_FFFF, 0));
    send_word(cmd_of(K_WRITE, NUM_WORDS - 1, 32'h0, 255));
    send_word(cmd_of(K_READ, 0, '0, 0));
    send_word(cmd_of(K_READ, NUM_WORDS - 1, '1, 0));
    // erase past the end gets clipped
    send_word(cmd_of(K_ERASE, NUM_WORDS - 2, '1, 255));
    send_word(cmd_of(K_READ, NUM_WORDS - 1, '0, 0));
    send_word(cmd_of(K_ERASE, 5, '0, 0));
    send_word(cmd_of(K_FLUSH, 0, '0, 0));
    send_word(cmd_of(K_READ, 0, '0, 0));
    send_word(cmd_of(K_FLUSH, 77, '1, 255));
    send_word(cmd_of(K_FULL, 3, 32'hA5A5_5A5A, 9));
    send_word(cmd_of(K_READ, 100, '0, 0));
    send_word(cmd_of(K_WRITE, 64, 32'h1234_5678, 0));
    send_word(cmd_of(K_READ, 64, '0, 0));
    send_word(cmd_of(K_DISCARD, 64, '1, 1));
    send_word(cmd_of(K_READ, 64, '0, 0));
    send_word(cmd_of(KIND_UNUSED_6, 12, '1, 255));
    send_word(cmd_of(KIND_UNUSED_7, 0, 32'h5A5A_A5A5, 128));
    send_word(cmd_of(K_ERASE, 0, '0, 128));
    send_word(cmd_of(K_READ, 63, '0, 0));
    send_word(cmd_of(K_WRITE, NUM_WORDS - 1, 32'hFFFF_FFFF, 0));
    send_word(cmd_of(K_READ, NUM_WORDS - 1, '0, 0));
  endtask

  task automatic test_threshold_low();
    set_flush_threshold(4'd1);
    run_random_traffic(150);
    // zero flushes on every write or erase
    set_flush_threshold(4'd0);
    run_random_traffic(100);
  endtask

  task automatic test_default_threshold();
    set_flush_threshold(THRESH_RST);
    run_random_traffic(250);
  endtask

  task automatic test_threshold_high();
    set_flush_threshold(4'd15);
    run_random_traffic(250);
  endtask

  task automatic test_mixed_thresholds();
    for (int i = 0; i < 5; i++) begin
      set_flush_threshold(THR_W'($urandom_range(2, 14)));
      run_random_traffic(60);
    end
  endtask

  task automatic test_backpressure();
    set_flush_threshold(4'd6);
    hold_request = LONG_HOLD;
    run_random_traffic(120);
  endtask

  task automatic test_streaming();
    set_flush_threshold(THR_W'($urandom_range(1, 15)));
    run_random_traffic(430);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    cmd.valid = 1'b0;
    cmd.kind = '0;
    cmd.lba = '0;
    cmd.data = '0;
    cmd.length = '0;
    rsp.ready = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    hold_request = 0;
    hold_left = 0;
    hot_base = '0;
    for (int a = 0; a < NUM_WORDS; a++) begin
      store_word[a] = '0;
      pend_word[a] = '0;
      pend_vld[a] = 1'b0;
    end
    cmd_count = '0;
    flush_thresh = THRESH_RST;
    src_idle_pct = 37;
    sink_idle_pct = 78;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_commands();
    test_threshold_low();
    test_default_threshold();
    src_idle_pct = 78;
    sink_idle_pct = 37;
    test_threshold_high();
    test_mixed_thresholds();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_backpressure();
    test_streaming();

    wait_for_results(1'b1);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
